### rtl/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

    localparam int CP_W       = 21;
    localparam int USED_W     = 3;
    localparam int ACC_W      = 31;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CP_W-1:0] REP_RESET = 21'd65533;

    // Register index taken from the upper address bit.
    localparam logic REG_REPLACEMENT = 1'b0;

    localparam logic [ACC_W-1:0] SURR_LO  = 31'h0000D800;
    localparam logic [ACC_W-1:0] SURR_HI  = 31'h0000DFFF;
    localparam logic [ACC_W-1:0] CP_MAX   = 31'h0010FFFF;
    localparam logic [ACC_W-1:0] NONCHAR0 = 31'h0000FFFE;
    localparam logic [ACC_W-1:0] NONCHAR1 = 31'h0000FFFF;

    localparam logic [7:0] OVL_MASK  = 8'hDE;
    localparam logic [7:0] CONT_BITS = 8'h3F;
    localparam logic [7:0] TAG_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    typedef struct packed {
        logic [CP_W-1:0]   code_point;
        logic              was_invalid;
        logic [USED_W-1:0] bytes_used;
        logic              text_done;
    } result_t;

    // Work for one byte: an optional break result, then an optional main result.
    typedef struct packed {
        logic              brk;
        logic [USED_W-1:0] brk_used;
        logic              main_vld;
        result_t           main;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

### rtl/u8d_in_if.sv
// Input byte channel.
interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

### rtl/u8d_out_if.sv
// Decoded character channel.
interface u8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        was_invalid;
    logic [2:0]  bytes_used;
    logic        text_done;
    logic        run_last;

    modport source (output valid, output code_point, output was_invalid,
                    output bytes_used, output text_done, output run_last, input ready);
    modport sink (input valid, input code_point, input was_invalid,
                  input bytes_used, input text_done, input run_last, output ready);
endinterface

### rtl/u8d_cfg.sv
// APB register block holding the replacement code.
module u8d_cfg
    import u8d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CP_W-1:0]       rep_code
);

    logic [CP_W-1:0] rep_reg;
    logic [CP_W-1:0] rep_next;
    logic            hit;

    assign pready = 1'b1;
    assign hit    = (paddr[APB_ADDR_W-1] == REG_REPLACEMENT);

    always_comb
    begin
        rep_next = rep_reg;
        if (psel && penable && pwrite && hit)
        begin
            rep_next = pwdata[CP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_reg <= REP_RESET;
        end
        else
        begin
            rep_reg <= rep_next;
        end
    end

    assign prdata   = hit ? {{(APB_DATA_W-CP_W){1'b0}}, rep_reg} : '0;
    assign rep_code = rep_reg;

endmodule

### rtl/u8d_front.sv
// Front end: accepts bytes, tracks the pending sequence and classifies results.
module u8d_front
    import u8d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    u8d_in_if.sink          in_ch,
    input  logic [CP_W-1:0] rep_code,
    input  q_status_t       q_stat,
    output logic            push,
    output job_t            job
);

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [2:0]        left_reg, left_next;
    logic [2:0]        taken_reg, taken_next;
    logic [2:0]        len_reg, len_next;
    logic              minimal_reg, minimal_next;
    logic              overlong_reg, overlong_next;

    logic [7:0]        b;
    logic              eot;
    logic              cont;
    logic              ov;
    logic [7:0]        mask;
    logic [7:0]        bits;
    logic [2:0]        len;
    logic [ACC_W-1:0]  acc_c;
    logic [2:0]        taken_c;
    logic [2:0]        left_c;
    logic              bad;
    logic              accept;

    assign b      = in_ch.in_byte;
    assign eot    = in_ch.end_of_text;
    assign cont   = ((b & TAG_MASK) == CONT_TAG);
    assign accept = in_ch.valid && in_ch.ready;

    assign in_ch.ready = !q_stat.full;

    always_comb
    begin
        acc_next      = acc_reg;
        left_next     = left_reg;
        taken_next    = taken_reg;
        len_next      = len_reg;
        minimal_next  = minimal_reg;
        overlong_next = overlong_reg;
        job           = '0;
        ov            = overlong_reg;
        mask          = 8'hFC;
        bits          = '0;
        len           = 3'd2;
        acc_c         = {acc_reg[ACC_W-7:0], b[5:0]};
        taken_c       = taken_reg + 3'd1;
        left_c        = left_reg - 3'd1;
        bad           = 1'b0;

        if ((left_reg != 3'd0) && cont)
        begin
            // The first byte after a minimal lead must carry enough bits.
            if ((taken_reg == 3'd1) && minimal_reg)
            begin
                case (len_reg)
                    3'd3:    mask = 8'hE0;
                    3'd4:    mask = 8'hF0;
                    3'd5:    mask = 8'hF8;
                    default: mask = 8'hFC;
                endcase
                if ((b & mask) == CONT_TAG)
                begin
                    ov = 1'b1;
                end
            end
            bad = ov || ((acc_c >= SURR_LO) && (acc_c <= SURR_HI))
                  || (acc_c == NONCHAR0) || (acc_c == NONCHAR1) || (acc_c > CP_MAX);
            if (left_c == 3'd0)
            begin
                job.main_vld         = 1'b1;
                job.main.code_point  = bad ? rep_code : acc_c[CP_W-1:0];
                job.main.was_invalid = bad;
                job.main.bytes_used  = taken_c;
                job.main.text_done   = eot;
            end
            else if (eot)
            begin
                job.main_vld         = 1'b1;
                job.main.code_point  = rep_code;
                job.main.was_invalid = 1'b1;
                job.main.bytes_used  = taken_c;
                job.main.text_done   = 1'b1;
            end
            if ((left_c == 3'd0) || eot)
            begin
                acc_next      = '0;
                left_next     = '0;
                taken_next    = '0;
                len_next      = '0;
                minimal_next  = 1'b0;
                overlong_next = 1'b0;
            end
            else
            begin
                acc_next      = acc_c;
                left_next     = left_c;
                taken_next    = taken_c;
                overlong_next = ov;
            end
        end
        else
        begin
            // A byte that breaks a pending sequence ends it, then starts afresh.
            job.brk       = (left_reg != 3'd0);
            job.brk_used  = taken_reg;
            acc_next      = '0;
            left_next     = '0;
            taken_next    = '0;
            len_next      = '0;
            minimal_next  = 1'b0;
            overlong_next = 1'b0;

            if (b < 8'h80)
            begin
                job.main_vld         = 1'b1;
                job.main.code_point  = {{(CP_W-8){1'b0}}, b};
                job.main.was_invalid = 1'b0;
                job.main.bytes_used  = 3'd1;
                job.main.text_done   = eot;
            end
            else if ((b < 8'hC0) || (b >= 8'hFE))
            begin
                job.main_vld         = 1'b1;
                job.main.code_point  = rep_code;
                job.main.was_invalid = 1'b1;
                job.main.bytes_used  = 3'd1;
                job.main.text_done   = eot;
            end
            else
            begin
                if (b >= 8'hFC)
                begin
                    len  = 3'd6;
                    bits = b & 8'h01;
                end
                else if (b >= 8'hF8)
                begin
                    len  = 3'd5;
                    bits = b & 8'h03;
                end
                else if (b >= 8'hF0)
                begin
                    len  = 3'd4;
                    bits = b & 8'h07;
                end
                else if (b >= 8'hE0)
                begin
                    len  = 3'd3;
                    bits = b & 8'h0F;
                end
                else
                begin
                    len  = 3'd2;
                    bits = b & 8'h1F;
                end

                if (eot)
                begin
                    job.main_vld         = 1'b1;
                    job.main.code_point  = rep_code;
                    job.main.was_invalid = 1'b1;
                    job.main.bytes_used  = 3'd1;
                    job.main.text_done   = 1'b1;
                end
                else
                begin
                    acc_next      = {{(ACC_W-8){1'b0}}, bits};
                    len_next      = len;
                    left_next     = len - 3'd1;
                    taken_next    = 3'd1;
                    minimal_next  = b inside {8'hE0, 8'hF0, 8'hF8, 8'hFC};
                    overlong_next = ((b & OVL_MASK) == TAG_MASK);
                end
            end
        end
    end

    assign push = accept && (job.brk || job.main_vld);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            left_reg     <= '0;
            taken_reg    <= '0;
            len_reg      <= '0;
            minimal_reg  <= 1'b0;
            overlong_reg <= 1'b0;
        end
        else if (accept)
        begin
            acc_reg      <= acc_next;
            left_reg     <= left_next;
            taken_reg    <= taken_next;
            len_reg      <= len_next;
            minimal_reg  <= minimal_next;
            overlong_reg <= overlong_next;
        end
    end

`ifndef SYNTHESIS
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg != 3'd0) |-> ((taken_reg + left_reg) == len_reg))
        else $error("pending byte counts disagree with the lead length");
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg == 3'd0) |-> (taken_reg == 3'd0))
        else $error("bytes taken left over with no sequence pending");
`endif

endmodule

### rtl/u8d_queue.sv
// Small register queue of per-byte jobs between front and back ends.
module u8d_queue
    import u8d_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head,
    output q_status_t q_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    assign head         = mem[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("job written into a full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("job taken from an empty queue");
`endif

endmodule

### rtl/u8d_back.sv
// Back end: plays out the one or two results of each queued job.
module u8d_back
    import u8d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  job_t            head,
    input  q_status_t       q_stat,
    input  logic [CP_W-1:0] rep_code,
    output logic            pop,
    u8d_out_if.source       out_ch
);

    logic sub_reg, sub_next;
    logic show_brk;
    logic accept;

    // The break result goes first; the main result follows on the next beat.
    assign show_brk = head.brk && !sub_reg;
    assign accept   = out_ch.valid && out_ch.ready;

    assign out_ch.valid       = !q_stat.empty;
    assign out_ch.code_point  = show_brk ? rep_code : head.main.code_point;
    assign out_ch.was_invalid = show_brk ? 1'b1 : head.main.was_invalid;
    assign out_ch.bytes_used  = show_brk ? head.brk_used : head.main.bytes_used;
    assign out_ch.text_done   = show_brk ? 1'b0 : head.main.text_done;
    assign out_ch.run_last    = show_brk ? !head.main_vld : 1'b1;

    always_comb
    begin
        sub_next = sub_reg;
        pop      = 1'b0;
        if (accept)
        begin
            if (show_brk && head.main_vld)
            begin
                sub_next = 1'b1;
            end
            else
            begin
                sub_next = 1'b0;
                pop      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= 1'b0;
        end
        else
        begin
            sub_reg <= sub_next;
        end
    end

`ifndef SYNTHESIS
    a_second_beat: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> (!q_stat.empty && head.brk && head.main_vld))
        else $error("second beat pending without a two-result job");
`endif

endmodule

### rtl/utf8_stream_decoder_core.sv
// Top level of the UTF-8 stream decoder.
//
//  Channel  Dir  Handshake           Beat
//  in_ch    in   valid/ready         one raw byte with end-of-text mark
//  out_ch   out  valid/ready         one decoded character or replacement
//  APB      in   psel/penable/pwrite replacement code register at addresses 0 to 3
//
// One byte is accepted per cycle while the job queue has room.
// A byte that breaks a pending sequence and also yields its own character
// takes two output beats; the single output port sets that rate.
// Bytes that only extend a sequence produce no beat.
// Reset is asynchronous and active low; the block is ready right after it.
// A stalled output fills the job queue, after which input ready drops.
module utf8_stream_decoder_core
    import u8d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    u8d_in_if.sink                in_ch,
    u8d_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CP_W-1:0] rep_code;
    q_status_t       q_stat;
    logic            push;
    logic            pop;
    job_t            push_job;
    job_t            head;

    u8d_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .rep_code (rep_code)
    );

    u8d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .rep_code (rep_code),
        .q_stat   (q_stat),
        .push     (push),
        .job      (push_job)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    u8d_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_stat   (q_stat),
        .rep_code (rep_code),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule
